>>> hdl/assert_macros.svh
// Assertion macros for the RTL; delayed_line_memory includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLM_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/dlm_pkg.sv
// Types and constants of the delayed line memory.
package dlm_pkg;

    localparam int unsigned MEM_WORDS_DEF  = 32768;
    localparam int unsigned LINE_WORDS_DEF = 4;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned DELAY_W        = 8;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd3;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DECIDE,
        S_OFFSET,
        S_RD_ADDR,
        S_RD_DATA,
        S_EMIT
    } dlm_state_t;

    typedef struct packed {
        logic              mode;
        logic [1:0]        requester;
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  read_word;
        logic               last;
        logic               busy_res;
        logic [DELAY_W-1:0] cycles_left;
        logic [1:0]         owner_stage;
    } res_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

>>> hdl/dlm_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
interface dlm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/dlm_mod.sv
// Remainder by a constant divisor: a mask for a power of two, else a reciprocal multiply.
module dlm_mod
    import dlm_pkg::*;
#(
    parameter int unsigned DIV  = 3,
    parameter int unsigned IN_W = 32,
    localparam int unsigned RES_W = (DIV > 1) ? $clog2(DIV) : 1
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IN_W-1:0]  dividend,
    output logic             done,
    output logic [RES_W-1:0] rem
);

    localparam bit POW2 = ((DIV & (DIV - 1)) == 0);
    // (dividend * MULT) >> SHIFT is the exact quotient for every IN_W-bit dividend
    localparam int unsigned SHIFT  = IN_W + RES_W;
    localparam int unsigned PROD_W = 2 * IN_W + RES_W;
    localparam longint unsigned MULT_L = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [IN_W:0] MULT = (IN_W + 1)'(MULT_L);
    localparam logic [RES_W-1:0] DIV_LO = RES_W'(DIV);
    localparam logic [RES_W-1:0] MASK = RES_W'(DIV - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [RES_W-1:0]  low_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [RES_W-1:0]  quot_lo;

    assign quot_lo = prod_reg[SHIFT +: RES_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // a power of two reduces to a mask in the start cycle
            busy_reg <= start && !POW2;
            done_reg <= (start && POW2) || busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            low_reg  <= dividend[RES_W-1:0];
            prod_reg <= PROD_W'(dividend) * PROD_W'(MULT);
        end
        if (start && POW2)
        begin
            rem_reg <= dividend[RES_W-1:0] & MASK;
        end
        else if (busy_reg)
        begin
            // the remainder fits RES_W bits, so low bits of the product suffice
            rem_reg <= low_reg - quot_lo * DIV_LO;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/dlm_mem.sv
// Single-port word store with registered read data.
module dlm_mem
    import dlm_pkg::*;
#(
    parameter int unsigned DEPTH = MEM_WORDS_DEF,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
)(
    input  logic              clk,
    input  mem_cmd_t          cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_array[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/delayed_line_memory.sv
// Top level: request sequencer of the delayed line memory.
//
//  channel | dir | payload                                    | request taken when
//  req     | in  | mode, requester, address, write_data       | valid && ready
//  rsp     | out | status, read_word, last, busy_res,         | valid && ready
//          |     | cycles_left, owner_stage                   |
//  cfg     | in  | access_delay (8 bits)                      | valid (ready tied high)
//
// A request passes S_IDLE, S_REDUCE (address reduction modulo MEM_WORDS), S_DECIDE and
// S_EMIT; a requester-zero request goes from S_IDLE straight to S_EMIT. A completed line
// read spends its offset reduction (S_OFFSET) in place of S_EMIT, then does for each word
// a memory read (S_RD_ADDR) and an output load (S_RD_DATA). After reset the store is
// zeroed one word a cycle, with req.ready low. A stalled rsp holds the result in the output
// register; the next request is still taken while it waits.
`include "assert_macros.svh"
module delayed_line_memory
    import dlm_pkg::*;
#(
    parameter int unsigned MEM_WORDS  = MEM_WORDS_DEF,
    parameter int unsigned LINE_WORDS = LINE_WORDS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    dlm_stream_if.sink    req,
    dlm_stream_if.source  rsp,
    dlm_stream_if.sink    cfg
);

    localparam int unsigned ADDR_W = $clog2(MEM_WORDS);
    localparam int unsigned OFF_W  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;

    dlm_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_idx_reg, clr_idx_next;
    req_t               req_reg, req_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [1:0]         pend_stage_reg, pend_stage_next;
    logic               pend_write_reg, pend_write_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [WORD_W-1:0]  pend_data_reg, pend_data_next;
    logic [DELAY_W-1:0] countdown_reg, countdown_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    status_t            status_reg, status_next;
    logic [OFF_W-1:0]   word_idx_reg, word_idx_next;
    logic [ADDR_W-1:0]  word_addr_reg, word_addr_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    mem_cmd_t           mem_cmd;
    logic [ADDR_W-1:0]  mem_addr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;

    logic               red_start, red_done;
    logic [ADDR_W-1:0]  red_addr;
    logic               off_start, off_done;
    logic [OFF_W-1:0]   off_val;
    logic               out_free;
    logic               pend_match;

    dlm_mod #(
        .DIV  (MEM_WORDS),
        .IN_W (WORD_W)
    ) u_addr_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (red_start),
        .dividend (req.payload.address),
        .done     (red_done),
        .rem      (red_addr)
    );

    dlm_mod #(
        .DIV  (LINE_WORDS),
        .IN_W (ADDR_W)
    ) u_line_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (off_start),
        .dividend (red_addr),
        .done     (off_done),
        .rem      (off_val)
    );

    dlm_mem #(
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign delay_next  = cfg.valid ? cfg.payload : delay_reg;

    // a read ignores write_data in the compare
    assign pend_match = (pend_stage_reg == req_reg.requester)
                     && (pend_write_reg == req_reg.mode)
                     && (pend_addr_reg == red_addr)
                     && ((req_reg.mode == MODE_READ) || (pend_data_reg == req_reg.write_data));

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        req_next        = req_reg;
        pend_valid_next = pend_valid_reg;
        pend_stage_next = pend_stage_reg;
        pend_write_next = pend_write_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        countdown_next  = countdown_reg;
        status_next     = status_reg;
        word_idx_next   = word_idx_reg;
        word_addr_next  = word_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        red_start       = 1'b0;
        off_start       = 1'b0;
        mem_cmd         = '0;
        mem_addr        = word_addr_reg;
        mem_wdata       = req_reg.write_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.wr   = 1'b1;
                mem_addr     = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = req.payload;
                    if (req.payload.requester == 2'd0)
                    begin
                        status_next = ST_ERROR;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (red_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                status_next = ST_WAIT;
                state_next  = S_EMIT;
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_stage_next = req_reg.requester;
                    pend_write_next = req_reg.mode;
                    pend_addr_next  = red_addr;
                    pend_data_next  = (req_reg.mode == MODE_WRITE) ? req_reg.write_data : '0;
                    countdown_next  = delay_reg;
                end
                else if (!pend_match)
                begin
                    status_next = ST_WAIT;
                end
                else if (countdown_reg > DELAY_W'(1))
                begin
                    countdown_next = countdown_reg - 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    pend_stage_next = '0;
                    pend_write_next = 1'b0;
                    pend_addr_next  = '0;
                    pend_data_next  = '0;
                    countdown_next  = '0;
                    if (req_reg.mode == MODE_WRITE)
                    begin
                        mem_cmd.wr  = 1'b1;
                        mem_addr    = red_addr;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        off_start  = 1'b1;
                        state_next = S_OFFSET;
                    end
                end
            end
            S_OFFSET:
            begin
                if (off_done)
                begin
                    word_addr_next = red_addr - ADDR_W'(off_val);
                    word_idx_next  = '0;
                    state_next     = S_RD_ADDR;
                end
            end
            S_RD_ADDR:
            begin
                mem_cmd.rd = 1'b1;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = ST_DONE;
                    out_next.read_word   = mem_rdata;
                    out_next.last        = (word_idx_reg == OFF_W'(LINE_WORDS - 1));
                    out_next.busy_res    = pend_valid_reg;
                    out_next.cycles_left = countdown_reg;
                    out_next.owner_stage = pend_stage_reg;
                    word_idx_next        = word_idx_reg + 1'b1;
                    // line words wrap at the end of the store
                    word_addr_next = (word_addr_reg == ADDR_W'(MEM_WORDS - 1))
                                   ? '0 : word_addr_reg + 1'b1;
                    state_next = (word_idx_reg == OFF_W'(LINE_WORDS - 1)) ? S_IDLE : S_RD_ADDR;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.read_word   = '0;
                    out_next.last        = 1'b1;
                    out_next.busy_res    = pend_valid_reg;
                    out_next.cycles_left = countdown_reg;
                    out_next.owner_stage = pend_stage_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_stage_reg <= '0;
            pend_write_reg <= 1'b0;
            pend_addr_reg  <= '0;
            pend_data_reg  <= '0;
            countdown_reg  <= '0;
            delay_reg      <= DELAY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_stage_reg <= pend_stage_next;
            pend_write_reg <= pend_write_next;
            pend_addr_reg  <= pend_addr_next;
            pend_data_reg  <= pend_data_next;
            countdown_reg  <= countdown_next;
            delay_reg      <= delay_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        status_reg    <= status_next;
        word_idx_reg  <= word_idx_next;
        word_addr_reg <= word_addr_next;
        out_reg       <= out_next;
    end

    `DLM_ASSERT_IMPL(a_mem_excl, mem_cmd.wr, !mem_cmd.rd, "memory read and write in one cycle")
    `DLM_ASSERT_IMPL(a_idle_fields, rsp.valid && !rsp.payload.busy_res, rsp.payload.cycles_left == 8'd0 && rsp.payload.owner_stage == 2'd0, "idle result reports a countdown or owner")
    `DLM_ASSERT_IMPL(a_done_free, rsp.valid && rsp.payload.status == ST_DONE, !rsp.payload.busy_res, "completed access still reported busy")
    `DLM_ASSERT_IMPL(a_pend_load, $rose(pend_valid_reg), $past(state_reg) == S_DECIDE, "pending request latched outside decision")
    `DLM_ASSERT_NEXT(a_req_reduce, req.valid && req.ready && req.payload.requester != 2'd0, state_reg == S_REDUCE, "accepted request skipped address reduction")

endmodule

>>> tb/sv/delayed_line_memory_tb.sv
// Testbench of delayed_line_memory: directed table then random requests, checked by a predictor.
module delayed_line_memory_tb;
    import dlm_pkg::*;

    localparam int unsigned MEMW  = MEM_WORDS_DEF;
    localparam int unsigned LINEW = LINE_WORDS_DEF;
    localparam int          NUM_PHASES = 6;

    typedef struct {
        req_t rq;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dlm_stream_if #(.T(req_t))                 req_ch ();
    dlm_stream_if #(.T(res_t))                 rsp_ch ();
    dlm_stream_if #(.T(logic [DELAY_W-1:0]))   cfg_ch ();

    delayed_line_memory uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predictor state
    logic [WORD_W-1:0]  store_image [MEMW];
    logic [DELAY_W-1:0] delay_model;
    logic               pend_valid;
    logic [1:0]         pend_stage;
    logic               pend_wr;
    int unsigned        pend_addr;
    logic [WORD_W-1:0]  pend_data;
    logic [DELAY_W-1:0] pend_cnt;

    res_t access_batch [$];
    res_t rsp_due [$];
    int   errors;
    bit   no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_pending();
        pend_valid = 1'b0;
        pend_stage = 2'd0;
        pend_wr    = MODE_READ;
        pend_addr  = 0;
        pend_data  = '0;
        pend_cnt   = '0;
    endfunction

    function automatic void add_result(status_t st, logic [WORD_W-1:0] word, logic lst);
        res_t x;
        x.status      = st;
        x.read_word   = word;
        x.last        = lst;
        x.busy_res    = pend_valid;
        x.cycles_left = pend_valid ? pend_cnt : '0;
        x.owner_stage = pend_valid ? pend_stage : 2'd0;
        access_batch.push_back(x);
    endfunction

    function automatic void predict_access(input req_t r);
        int unsigned       a;
        int unsigned       base;
        int                i;
        logic [WORD_W-1:0] line [LINEW];
        access_batch.delete();
        a = r.address % MEMW;
        if (r.requester == 2'd0)
        begin
            add_result(ST_ERROR, '0, 1'b1);
            return;
        end
        if (!pend_valid)
        begin
            pend_valid = 1'b1;
            pend_stage = r.requester;
            pend_wr    = r.mode;
            pend_addr  = a;
            pend_data  = (r.mode == MODE_WRITE) ? r.write_data : '0;
            pend_cnt   = delay_model;
            add_result(ST_WAIT, '0, 1'b1);
            return;
        end
        if (pend_stage != r.requester || pend_wr != r.mode || pend_addr != a ||
            (r.mode == MODE_WRITE && pend_data != r.write_data))
        begin
            add_result(ST_WAIT, '0, 1'b1);
            return;
        end
        // zero delay behaves like one
        if (pend_cnt > 1)
        begin
            pend_cnt = pend_cnt - 1'b1;
            add_result(ST_WAIT, '0, 1'b1);
            return;
        end
        if (r.mode == MODE_WRITE)
        begin
            store_image[a] = r.write_data;
            clear_pending();
            add_result(ST_DONE, '0, 1'b1);
            return;
        end
        base = (a / LINEW) * LINEW;
        for (i = 0; i < LINEW; i++)
            line[i] = store_image[(base + i) % MEMW];
        clear_pending();
        for (i = 0; i < LINEW; i++)
            add_result(ST_DONE, line[i], i == LINEW - 1);
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [31:0] hi;
        hi = $urandom & ~(MEMW - 1);
        case ($urandom_range(3))
            0:       return hi | $urandom_range(MEMW - 1);
            1:       return hi | (MEMW - 1 - $urandom_range(15));
            default: return hi | $urandom_range(31);
        endcase
    endfunction

    // mostly repeats of the pending request so accesses complete; some near misses and errors
    function automatic req_t next_request();
        req_t        r;
        int unsigned pick;
        pick         = $urandom_range(99);
        r.mode       = 1'($urandom_range(1));
        r.requester  = 2'($urandom_range(3, 1));
        r.address    = pick_addr();
        r.write_data = $urandom;
        if (pick < 10)
            r.requester = 2'd0;
        else if (pend_valid && pick < 80)
        begin
            r.mode      = pend_wr;
            r.requester = pend_stage;
            r.address   = ($urandom & ~(MEMW - 1)) | pend_addr;
            if (pend_wr == MODE_WRITE)
                r.write_data = pend_data;
            if (pick >= 68)
            begin
                case ($urandom_range(3))
                    0:       r.mode = ~r.mode;
                    1:       r.requester = (pend_stage == 2'd3) ? 2'd1 : pend_stage + 2'd1;
                    2:       r.address = r.address ^ (32'd1 << $urandom_range(14));
                    default: r.write_data = r.write_data ^ (32'd1 << $urandom_range(31));
                endcase
            end
        end
        return r;
    endfunction

    function automatic dir_row_t row(logic m, logic [1:0] s, logic [31:0] a, logic [31:0] d,
                                     bit typed, status_t st, logic busy, logic [7:0] cl,
                                     logic [1:0] own);
        dir_row_t x;
        x.rq.mode             = m;
        x.rq.requester        = s;
        x.rq.address          = a;
        x.rq.write_data       = d;
        x.typed               = typed;
        x.want.status         = st;
        x.want.read_word      = '0;
        x.want.last           = 1'b1;
        x.want.busy_res       = busy;
        x.want.cycles_left    = cl;
        x.want.owner_stage    = own;
        return x;
    endfunction

    task automatic send_request(input req_t r, input bit typed, input res_t want);
        int gap;
        if (!no_idle && $urandom_range(7) == 0)
        begin
            req_ch.valid = 1'b0;
            gap = $urandom_range(17, 1);
            repeat (gap) @(negedge clk);
        end
        req_ch.payload = r;
        req_ch.valid   = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_access(r);
        if (typed)
            rsp_due.push_back(want);
        else
            foreach (access_batch[i])
                rsp_due.push_back(access_batch[i]);
        @(negedge clk);
    endtask

    // only with no response outstanding
    task automatic set_delay(input logic [DELAY_W-1:0] v);
        req_ch.valid = 1'b0;
        while (rsp_due.size() != 0)
            @(negedge clk);
        cfg_ch.payload = v;
        cfg_ch.valid   = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        delay_model = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // response side backpressure
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready = 1'b0;
            end
            else if (!no_idle && $urandom_range(9) == 0)
            begin
                hold = $urandom_range(17, 1) - 1;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        res_t want;
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (rsp_due.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual %0h", $time, got);
                errors++;
            end
            else
            begin
                want = rsp_due.pop_front();
                check_field("status", want.status, got.status);
                check_field("read_word", want.read_word, got.read_word);
                check_field("last", want.last, got.last);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("cycles_left", want.cycles_left, got.cycles_left);
                check_field("owner_stage", want.owner_stage, got.owner_stage);
            end
        end
    end

    initial
    begin
        dir_row_t           dir_rows [22];
        logic [DELAY_W-1:0] phase_delay [NUM_PHASES];
        int                 phase_items [NUM_PHASES];
        int                 p;
        res_t               none;

        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        none           = '0;
        errors         = 0;
        no_idle        = 1'b0;
        delay_model    = DELAY_RESET;
        clear_pending();
        foreach (store_image[i])
            store_image[i] = '0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // delay is at its reset value here
        dir_rows = '{
            row(MODE_READ,  2'd0, 32'h0000_0000, 32'h0, 1, ST_ERROR, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_WAIT, 1'b1, 8'd3, 2'd1),
            row(MODE_WRITE, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_WAIT, 1'b1, 8'd2, 2'd1),
            row(MODE_READ,  2'd1, 32'hFFFF_FFFF, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd0, 32'h0000_0004, 32'h0, 1, ST_ERROR, 1'b1, 8'd2, 2'd1),
            row(MODE_WRITE, 2'd1, 32'hFFFF_FFFF, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd1, 32'h0000_7FFF, 32'hFFFF_FFFF, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd2, 32'h0000_7FFD, 32'h0, 1, ST_WAIT, 1'b1, 8'd3, 2'd2),
            row(MODE_READ,  2'd2, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd2, 32'h0000_7FFD, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd2, 32'h0000_7FFD, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd3, 32'h8000_0001, 32'h1234_5678, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd3, 32'h0000_0001, 32'h1234_5678, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd3, 32'h0000_0001, 32'h1234_5678, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_WRITE, 2'd3, 32'h0000_8001, 32'h1234_5678, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd1, 32'h0000_0000, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd1, 32'h0001_0000, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd1, 32'h0000_0000, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            row(MODE_READ,  2'd1, 32'hFFFF_8000, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0),
            // left pending across the first delay change
            row(MODE_WRITE, 2'd2, 32'h0000_0002, 32'h0, 0, ST_WAIT, 1'b0, 8'd0, 2'd0)
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        phase_delay = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd4, 8'd255};
        phase_delay[3] = DELAY_W'($urandom_range(8, 1));
        phase_items = '{50, 50, 50, 50, 50, 60};
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_delay(phase_delay[p]);
            if (p == NUM_PHASES - 1)
                no_idle = 1'b1;
            repeat (phase_items[p])
                send_request(next_request(), 1'b0, none);
        end
        req_ch.valid = 1'b0;

        while (rsp_due.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (errors == 0 && rsp_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/dlm_pkg.sv
hdl/dlm_stream_if.sv
hdl/dlm_mod.sv
hdl/dlm_mem.sv
hdl/delayed_line_memory.sv
tb/sv/delayed_line_memory_tb.sv
